// ===== src/ibcs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer package
// Shared types, codes and defaults for the bus recovery sequencer.
// ----------------------------------------------------------------------------
package ibcs_pkg;

	localparam int TIMER_WIDTH_DEF = 8;
	localparam int CFG_DATA_W      = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int PULSE_W         = 4;

	localparam logic [7:0]         HALF_PERIOD_RST  = 8'd5;
	localparam logic [7:0]         RISE_TIMEOUT_RST = 8'd100;
	localparam logic [PULSE_W-1:0] MAX_PULSES_RST   = 4'd9;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_SETTLE      = 4'd1,
		PH_WAIT_SCL    = 4'd2,
		PH_PULSE_LOW   = 4'd3,
		PH_PULSE_WAIT  = 4'd4,
		PH_PULSE_HIGH  = 4'd5,
		PH_STOP_LOW    = 4'd6,
		PH_STOP_WAIT   = 4'd7,
		PH_STOP_HOLD   = 4'd8,
		PH_STOP_SETTLE = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		OC_NONE      = 2'd0,
		OC_RECOVERED = 2'd1,
		OC_FAILED    = 2'd2
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_PERIOD  = 2'd0,
		REG_RISE_TIMEOUT = 2'd1,
		REG_MAX_PULSES   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]         half_period_ticks;
		logic [7:0]         rise_timeout_ticks;
		logic [PULSE_W-1:0] max_pulses;
	} cfg_t;

	typedef struct packed {
		logic     scl_pull_low;
		logic     sda_pull_low;
		logic     controller_detached;
		logic     done_res;
		outcome_t outcome;
	} res_t;

	typedef struct packed {
		logic timeout_request;
		logic scl_level;
		logic sda_level;
	} tick_t;

endpackage

// ===== src/ibcs_ifs.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer channels
// Valid/ready channels for tick samples, results and register writes.
// ----------------------------------------------------------------------------
interface ibcs_tick_if;
	logic valid;
	logic ready;
	logic timeout_request;
	logic scl_level;
	logic sda_level;

	modport source (output valid, timeout_request, scl_level, sda_level, input ready);
	modport sink   (input valid, timeout_request, scl_level, sda_level, output ready);
endinterface

interface ibcs_result_if;
	logic       valid;
	logic       ready;
	logic       scl_pull_low;
	logic       sda_pull_low;
	logic       controller_detached;
	logic       done_res;
	logic [1:0] outcome;

	modport source (output valid, scl_pull_low, sda_pull_low, controller_detached,
		done_res, outcome, input ready);
	modport sink   (input valid, scl_pull_low, sda_pull_low, controller_detached,
		done_res, outcome, output ready);
endinterface

interface ibcs_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ibcs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer configuration registers
// Holds half period, rise timeout and pulse limit; writes always accepted.
// ----------------------------------------------------------------------------
module ibcs_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	ibcs_cfg_if.sink     cfg,
	output ibcs_pkg::cfg_t regs
);
	import ibcs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.half_period_ticks  <= HALF_PERIOD_RST;
			regs_q.rise_timeout_ticks <= RISE_TIMEOUT_RST;
			regs_q.max_pulses         <= MAX_PULSES_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_HALF_PERIOD:  regs_q.half_period_ticks  <= cfg.data;
				REG_RISE_TIMEOUT: regs_q.rise_timeout_ticks <= cfg.data;
				REG_MAX_PULSES:   regs_q.max_pulses         <= cfg.data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== src/ibcs_step.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer step logic
// Next phase, timer and pulse count for one tick, plus the drive levels.
// ----------------------------------------------------------------------------
module ibcs_step #(
	parameter int TIMER_WIDTH = ibcs_pkg::TIMER_WIDTH_DEF
) (
	input  ibcs_pkg::cfg_t                 regs,
	input  ibcs_pkg::tick_t                tick,
	input  ibcs_pkg::phase_t               phase,
	input  logic [TIMER_WIDTH-1:0]         timer,
	input  logic [ibcs_pkg::PULSE_W-1:0]   pulse_cnt,
	output ibcs_pkg::phase_t               phase_nxt,
	output logic [TIMER_WIDTH-1:0]         timer_nxt,
	output logic [ibcs_pkg::PULSE_W-1:0]   pulse_cnt_nxt,
	output ibcs_pkg::res_t                 res
);
	import ibcs_pkg::*;

	localparam int LW = (TIMER_WIDTH > 8) ? TIMER_WIDTH : 8;
	localparam logic [LW-1:0] TMAX_EXT = LW'({TIMER_WIDTH{1'b1}});

	logic [LW-1:0]          half_ext;
	logic [LW-1:0]          rise_ext;
	logic [TIMER_WIDTH-1:0] half_ld;
	logic [TIMER_WIDTH-1:0] rise_ld;
	logic                   expired;
	logic                   rise_fail;
	logic [PULSE_W-1:0]     dec_cnt;
	logic                   more_pulses;
	logic                   done;
	outcome_t               oc;
	phase_t                 ph_n;
	logic [TIMER_WIDTH-1:0] tm_n;
	logic [PULSE_W-1:0]     pc_n;

	// saturate register values into the timer range
	assign half_ext = LW'(regs.half_period_ticks);
	assign rise_ext = LW'(regs.rise_timeout_ticks);
	assign half_ld  = TIMER_WIDTH'((half_ext > TMAX_EXT) ? TMAX_EXT : half_ext);
	assign rise_ld  = TIMER_WIDTH'((rise_ext > TMAX_EXT) ? TMAX_EXT : rise_ext);

	assign expired   = (timer <= TIMER_WIDTH'(1));
	assign rise_fail = (timer >= rise_ld);

	// pulse count seen by the pulse decision: cleared on first rise, bumped after a pulse
	assign dec_cnt     = (phase == PH_PULSE_HIGH) ? pulse_cnt + PULSE_W'(1) : '0;
	assign more_pulses = (dec_cnt < regs.max_pulses);

	always_comb begin
		ph_n = phase;
		tm_n = timer;
		pc_n = pulse_cnt;
		done = 1'b0;
		oc   = OC_NONE;
		case (phase)
			PH_SETTLE, PH_PULSE_LOW, PH_STOP_LOW: begin
				if (expired) begin
					tm_n = '0;
					case (phase)
						PH_SETTLE:    ph_n = PH_WAIT_SCL;
						PH_PULSE_LOW: ph_n = PH_PULSE_WAIT;
						default:      ph_n = PH_STOP_WAIT;
					endcase
				end else begin
					tm_n = timer - TIMER_WIDTH'(1);
				end
			end
			PH_WAIT_SCL, PH_PULSE_WAIT, PH_STOP_WAIT: begin
				if (tick.scl_level) begin
					if (phase == PH_WAIT_SCL) begin
						pc_n = '0;
						if (!tick.sda_level && more_pulses) begin
							ph_n = PH_PULSE_LOW;
							tm_n = half_ld;
						end else if (!tick.sda_level) begin
							done = 1'b1;
							oc   = OC_FAILED;
						end else begin
							ph_n = PH_STOP_LOW;
							tm_n = half_ld;
						end
					end else if (phase == PH_PULSE_WAIT) begin
						ph_n = PH_PULSE_HIGH;
						tm_n = half_ld;
					end else begin
						ph_n = PH_STOP_HOLD;
						tm_n = half_ld;
					end
				end else if (rise_fail) begin
					done = 1'b1;
					oc   = OC_FAILED;
				end else begin
					tm_n = timer + TIMER_WIDTH'(1);
				end
			end
			PH_PULSE_HIGH: begin
				if (expired) begin
					pc_n = dec_cnt;
					if (!tick.sda_level && more_pulses) begin
						ph_n = PH_PULSE_LOW;
						tm_n = half_ld;
					end else if (!tick.sda_level) begin
						done = 1'b1;
						oc   = OC_FAILED;
					end else begin
						ph_n = PH_STOP_LOW;
						tm_n = half_ld;
					end
				end else begin
					tm_n = timer - TIMER_WIDTH'(1);
				end
			end
			PH_STOP_HOLD: begin
				if (expired) begin
					ph_n = PH_STOP_SETTLE;
					tm_n = half_ld;
				end else begin
					tm_n = timer - TIMER_WIDTH'(1);
				end
			end
			PH_STOP_SETTLE: begin
				if (expired) begin
					done = 1'b1;
					oc   = (tick.scl_level && tick.sda_level) ? OC_RECOVERED : OC_FAILED;
				end else begin
					tm_n = timer - TIMER_WIDTH'(1);
				end
			end
			default: begin
				ph_n = PH_IDLE;
				if (tick.timeout_request) begin
					pc_n = '0;
					ph_n = PH_SETTLE;
					tm_n = half_ld;
				end
			end
		endcase
		if (done) begin
			ph_n = PH_IDLE;
			tm_n = '0;
		end
	end

	assign phase_nxt     = ph_n;
	assign timer_nxt     = tm_n;
	assign pulse_cnt_nxt = pc_n;

	assign res.scl_pull_low        = (ph_n == PH_PULSE_LOW);
	assign res.sda_pull_low        = (ph_n == PH_STOP_LOW) || (ph_n == PH_STOP_WAIT) ||
		(ph_n == PH_STOP_HOLD);
	assign res.controller_detached = (ph_n != PH_IDLE);
	assign res.done_res            = done;
	assign res.outcome             = oc;

endmodule

// ===== src/i2c_bus_clear_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer
// Bus recovery by SCL pulses and a STOP, one tick sample per request.
// ----------------------------------------------------------------------------
//
//   channel  role   payload                                         handshake
//   tick     sink   timeout_request, scl_level, sda_level           valid/ready
//   result   source scl/sda_pull_low, controller_detached, done_res, outcome
//   cfg      sink   index (0 half period, 1 rise timeout, 2 pulses), data
//
// A tick request lands in the input register, then the step logic updates
// phase, timer and pulse count and loads the result register. One request
// per cycle is taken sustained while results are taken as they come, set
// by the single sequencer state update per tick.
// Reset clears phase, timer, pulse count and both valid flags and loads the
// register defaults. A stalled result holds the input register; cfg is
// always ready.
//
module i2c_bus_clear_sequencer_unit #(
	parameter int TIMER_WIDTH = ibcs_pkg::TIMER_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ibcs_tick_if.sink     tick,
	ibcs_result_if.source result,
	ibcs_cfg_if.sink      cfg
);
	import ibcs_pkg::*;

	cfg_t                   regs;
	tick_t                  tick_s1;
	logic                   valid_s1;
	res_t                   res_c;
	res_t                   result_q;
	logic                   out_valid_q;
	logic                   advance;
	phase_t                 phase_q;
	phase_t                 phase_nxt;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [TIMER_WIDTH-1:0] timer_nxt;
	logic [PULSE_W-1:0]     pulse_cnt_q;
	logic [PULSE_W-1:0]     pulse_cnt_nxt;

	ibcs_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ibcs_step #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_step (
		.regs          (regs),
		.tick          (tick_s1),
		.phase         (phase_q),
		.timer         (timer_q),
		.pulse_cnt     (pulse_cnt_q),
		.phase_nxt     (phase_nxt),
		.timer_nxt     (timer_nxt),
		.pulse_cnt_nxt (pulse_cnt_nxt),
		.res           (res_c)
	);

	// advance the sequencer when a tick waits and the result slot frees up
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	// input register: hold the sampled tick until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.timeout_request <= tick.timeout_request;
			tick_s1.scl_level       <= tick.scl_level;
			tick_s1.sda_level       <= tick.sda_level;
		end
	end

	// sequencer state: update once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			pulse_cnt_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_nxt;
			timer_q     <= timer_nxt;
			pulse_cnt_q <= pulse_cnt_nxt;
		end
	end

	// result register: drop valid once taken, load on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_c;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.scl_pull_low        = result_q.scl_pull_low;
	assign result.sda_pull_low        = result_q.sda_pull_low;
	assign result.controller_detached = result_q.controller_detached;
	assign result.done_res            = result_q.done_res;
	assign result.outcome             = result_q.outcome;

`ifndef SYNTHESIS
	// a finished recovery hands the lines back in the same result
	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.done_res |->
			!result_q.controller_detached && !result_q.scl_pull_low &&
			!result_q.sda_pull_low)
		else $error("done result still owns the bus");

	// an outcome is reported exactly on the done tick
	a_outcome_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.done_res == (result_q.outcome != OC_NONE)))
		else $error("outcome and done disagree");

	// never pull both lines at once
	a_one_line_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.scl_pull_low && result_q.sda_pull_low))
		else $error("both lines pulled low");

	// a stalled tick leaves the sequencer state untouched
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result.ready |=>
			$stable(phase_q) && $stable(timer_q) && $stable(pulse_cnt_q))
		else $error("sequencer moved while stalled");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// I2C bus clear sequencer testbench
// Feeds tick samples from a simple bus model with a stuck target, clock
// stretching and line noise, predicts the drive levels and outcome of every
// tick, and checks each result in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import ibcs_pkg::*;

	logic clk;
	logic arst_n;

	ibcs_tick_if   tick_ch();
	ibcs_result_if res_ch();
	ibcs_cfg_if    cfg_ch();

	i2c_bus_clear_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Sequencer prediction state: its own copy of the registers, phase,
	// tick timer and pulse count, advanced once per accepted request.
	// ------------------------------------------------------------------
	logic [7:0]         cfg_half;
	logic [7:0]         cfg_rise;
	logic [PULSE_W-1:0] cfg_maxp;
	phase_t             mdl_phase;
	logic [7:0]         mdl_timer;
	logic [PULSE_W-1:0] mdl_pulses;
	res_t               last_drive;	// levels after the latest accepted tick

	res_t expected_levels[$];	// predicted results, oldest first
	int   fail_count;

	// Idling controls shared by the sender, the receiver and the tests.
	bit send_idle_on;
	bit recv_idle_on;
	int recv_hold;	// long receiver hold-off, counted down by the receiver

	// Bus model: target holding SDA, clock stretching, stuck SCL, noise.
	int slave_hold;
	int stretch_left;
	int stretch_max;
	bit scl_stuck;
	bit noisy;
	bit prev_scl;

	// Count one tick of a delay phase; true once the delay has run out.
	function automatic bit delay_done();
		if (mdl_timer <= 8'd1)
			return 1'b1;
		mdl_timer = mdl_timer - 8'd1;
		return 1'b0;
	endfunction

	function automatic void start_delay(input phase_t nxt);
		mdl_phase = nxt;
		mdl_timer = cfg_half;
	endfunction

	function automatic void start_wait(input phase_t nxt);
		mdl_phase = nxt;
		mdl_timer = '0;
	endfunction

	// One SCL rise check: 1 risen, 0 still waiting, -1 timed out.
	function automatic int scl_rise(input logic scl);
		if (scl)
			return 1;
		if (mdl_timer >= cfg_rise)
			return -1;
		mdl_timer = mdl_timer + 8'd1;
		return 0;
	endfunction

	// Another pulse while SDA is low and pulses remain, else a STOP;
	// false when SDA is still low with no pulses left.
	function automatic bit pulse_or_stop(input logic sda);
		if (!sda && mdl_pulses < cfg_maxp) begin
			start_delay(PH_PULSE_LOW);
			return 1'b1;
		end
		if (!sda)
			return 1'b0;
		start_delay(PH_STOP_LOW);
		return 1'b1;
	endfunction

	// Advance the predicted sequencer by one tick and form its result.
	task automatic predict_tick(input tick_t tk, output res_t r);
		logic     done;
		outcome_t oc;
		int       rs;
		done = 1'b0;
		oc = OC_NONE;
		case (mdl_phase)
			PH_SETTLE: begin
				if (delay_done())
					start_wait(PH_WAIT_SCL);
			end
			PH_WAIT_SCL, PH_PULSE_WAIT: begin
				rs = scl_rise(tk.scl_level);
				if (rs < 0) begin
					done = 1'b1;
					oc = OC_FAILED;
				end else if (rs > 0) begin
					if (mdl_phase == PH_WAIT_SCL) begin
						mdl_pulses = '0;
						if (!pulse_or_stop(tk.sda_level)) begin
							done = 1'b1;
							oc = OC_FAILED;
						end
					end else begin
						start_delay(PH_PULSE_HIGH);
					end
				end
			end
			PH_PULSE_LOW: begin
				if (delay_done())
					start_wait(PH_PULSE_WAIT);
			end
			PH_PULSE_HIGH: begin
				if (delay_done()) begin
					mdl_pulses = mdl_pulses + PULSE_W'(1);
					if (!pulse_or_stop(tk.sda_level)) begin
						done = 1'b1;
						oc = OC_FAILED;
					end
				end
			end
			PH_STOP_LOW: begin
				if (delay_done())
					start_wait(PH_STOP_WAIT);
			end
			PH_STOP_WAIT: begin
				rs = scl_rise(tk.scl_level);
				if (rs < 0) begin
					done = 1'b1;
					oc = OC_FAILED;
				end else if (rs > 0) begin
					start_delay(PH_STOP_HOLD);
				end
			end
			PH_STOP_HOLD: begin
				if (delay_done())
					start_delay(PH_STOP_SETTLE);
			end
			PH_STOP_SETTLE: begin
				if (delay_done()) begin
					done = 1'b1;
					oc = (tk.scl_level && tk.sda_level) ? OC_RECOVERED : OC_FAILED;
				end
			end
			default: begin
				mdl_phase = PH_IDLE;
				if (tk.timeout_request) begin
					mdl_pulses = '0;
					start_delay(PH_SETTLE);
				end
			end
		endcase
		if (done) begin
			mdl_phase = PH_IDLE;
			mdl_timer = '0;
		end
		r.scl_pull_low        = (mdl_phase == PH_PULSE_LOW);
		r.sda_pull_low        = (mdl_phase == PH_STOP_LOW || mdl_phase == PH_STOP_WAIT ||
			mdl_phase == PH_STOP_HOLD);
		r.controller_detached = (mdl_phase != PH_IDLE);
		r.done_res            = done;
		r.outcome             = oc;
		last_drive = r;
	endtask

	// ------------------------------------------------------------------
	// Clock and run limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop the run if the handshakes ever hang.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side: one tick request, with a random idle gap in front.
	// Valid stays high across back-to-back requests.
	// ------------------------------------------------------------------
	task automatic send_tick(input logic req, input logic scl, input logic sda);
		int   gap;
		res_t want;
		tick_t tk;
		gap = send_idle_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			tick_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid           = 1'b1;
		tick_ch.timeout_request = req;
		tick_ch.scl_level       = scl;
		tick_ch.sda_level       = sda;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		tk.timeout_request = req;
		tk.scl_level       = scl;
		tk.sda_level       = sda;
		predict_tick(tk, want);
		expected_levels.push_back(want);
	endtask

	// Drop valid, wait for every predicted result, then let the
	// pipeline empty out.
	task automatic wait_drained();
		@(negedge clk);
		tick_ch.valid = 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write one register; the block must be idle and drained.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_HALF_PERIOD:  cfg_half = val;
			REG_RISE_TIMEOUT: cfg_rise = val;
			REG_MAX_PULSES:   cfg_maxp = val[PULSE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Feed ticks from the bus model. It reacts to the drive levels of the
	// previous tick: SCL follows the pull-down unless the target stretches
	// it or it is stuck, and SDA stays low while the target still holds it,
	// a hold that the rises of SCL wear down.
	task automatic drive_bus_ticks(input int count);
		logic req;
		logic scl;
		logic sda;
		logic [1:0] jolt;
		for (int n = 0; n < count; n++) begin
			req = last_drive.controller_detached ? ($urandom_range(0, 15) == 0) :
				($urandom_range(0, 3) == 0);
			if (!last_drive.controller_detached && req) begin
				// fresh bus fault: pick how the target misbehaves this time
				slave_hold   = $urandom_range(0, 17);
				scl_stuck    = ($urandom_range(0, 9) == 0);
				noisy        = ($urandom_range(0, 9) == 0);
				stretch_max  = ($urandom_range(0, 9) == 0) ? 300 : 3;
				stretch_left = 0;
			end
			if (last_drive.scl_pull_low) begin
				scl = 1'b0;
				stretch_left = $urandom_range(0, stretch_max);
			end else if (stretch_left > 0) begin
				scl = 1'b0;
				stretch_left--;
			end else begin
				scl = !scl_stuck;
			end
			if (scl && !prev_scl && slave_hold > 0)
				slave_hold--;
			sda = !last_drive.sda_pull_low && (slave_hold == 0);
			// occasional glitches, constant ones on a noisy bus
			if (noisy || $urandom_range(0, 49) == 0) begin
				jolt = 2'($urandom_range(0, 3));
				scl = jolt[1];
				sda = jolt[0];
			end
			prev_scl = scl;
			send_tick(req, scl, sda);
		end
	endtask

	// Run any recovery in progress to its end on a healthy bus.
	task automatic settle_to_idle();
		while (last_drive.controller_detached)
			send_tick(1'b0, 1'b1, 1'b1);
		scl_stuck  = 1'b0;
		noisy      = 1'b0;
		slave_hold = 0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked ticks with one-tick phases: idle line combinations,
	// SCL rise timeout, a request on the done tick, a request during
	// recovery, pulses running out, and a clean recovery.
	task automatic test_directed_cases();
		logic [2:0] seq [21] = '{
			3'b000, 3'b011, 3'b001, 3'b010,           // idle, all line levels
			3'b111, 3'b111, 3'b001, 3'b101,           // rise timeout, request on done
			3'b110, 3'b010, 3'b010, 3'b000, 3'b010,   // SDA stuck, one pulse
			3'b010,                                   // pulses used up
			3'b111, 3'b011, 3'b011, 3'b010, 3'b010,   // STOP sequence
			3'b010, 3'b011                            // final check recovers
		};
		write_reg(REG_HALF_PERIOD, 8'd1);
		write_reg(REG_RISE_TIMEOUT, 8'd1);
		write_reg(REG_MAX_PULSES, 8'd1);
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		foreach (seq[i])
			send_tick(seq[i][2], seq[i][1], seq[i][0]);
		settle_to_idle();
		wait_drained();
	endtask

	// Hold the receiver off for a long stretch while requests keep coming
	// back to back, so the block fills up and stalls its input.
	task automatic test_output_stall();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b1;
		recv_hold = 60;
		drive_bus_ticks(40);
		settle_to_idle();
		wait_drained();
	endtask

	// Random bus traffic under a series of register settings, extremes
	// included: zero delay and timeout, zero pulses, full-range values, and
	// a pulse count written with its upper data bits set.
	task automatic test_config_sweep();
		logic [7:0] half_set [9] = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd5, 8'd1, 8'd255, 8'd4, 8'd2};
		logic [7:0] rise_set [9] = '{8'd1, 8'd6, 8'd0, 8'd255, 8'd100, 8'd3, 8'd255, 8'd2, 8'd8};
		logic [7:0] maxp_set [9] = '{8'h01, 8'h09, 8'h00, 8'h0F, 8'h09, 8'hF3, 8'h0F, 8'h05,
			8'h0C};
		int         count_set [9] = '{55, 55, 55, 55, 55, 55, 100, 55, 55};
		foreach (half_set[p]) begin
			write_reg(REG_HALF_PERIOD, half_set[p]);
			write_reg(REG_RISE_TIMEOUT, rise_set[p]);
			write_reg(REG_MAX_PULSES, maxp_set[p]);
			// leave some phases without any idling on either side
			send_idle_on = ($urandom_range(0, 2) != 0);
			recv_idle_on = ($urandom_range(0, 2) != 0);
			drive_bus_ticks(count_set[p]);
			// shorten later delay phases so an open recovery ends quickly
			wait_drained();
			write_reg(REG_HALF_PERIOD, 8'd1);
			settle_to_idle();
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall per result, plus the long hold-off.
	// ------------------------------------------------------------------
	initial begin : result_ready_gen
		int gap;
		res_ch.ready = 1'b0;
		gap = 0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				res_ch.ready = 1'b0;
				recv_hold--;
			end else if (gap > 0) begin
				res_ch.ready = 1'b0;
				gap--;
			end else begin
				res_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				gap = recv_idle_on ? $urandom_range(0, 7) : 0;
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each accepted result with the oldest prediction.
	// ------------------------------------------------------------------
	initial begin : result_check
		res_t want;
		res_t got;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.scl_pull_low        = res_ch.scl_pull_low;
				got.sda_pull_low        = res_ch.sda_pull_low;
				got.controller_detached = res_ch.controller_detached;
				got.done_res            = res_ch.done_res;
				got.outcome             = outcome_t'(res_ch.outcome);
				if (expected_levels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result with nothing pending: %b",
							got);
				end else begin
					want = expected_levels.pop_front();
					if (got.scl_pull_low !== want.scl_pull_low ||
						got.sda_pull_low !== want.sda_pull_low ||
						got.controller_detached !== want.controller_detached ||
						got.done_res !== want.done_res ||
						got.outcome !== want.outcome) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch (expected/actual): scl_pull_low %b/%b ",
								"sda_pull_low %b/%b detached %b/%b done %b/%b ",
								"outcome %0d/%0d"},
								want.scl_pull_low, got.scl_pull_low,
								want.sda_pull_low, got.sda_pull_low,
								want.controller_detached, got.controller_detached,
								want.done_res, got.done_res,
								want.outcome, got.outcome);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// hold every input at a known value from time zero
		arst_n                  = 1'b0;
		tick_ch.valid           = 1'b0;
		tick_ch.timeout_request = 1'b0;
		tick_ch.scl_level       = 1'b0;
		tick_ch.sda_level       = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = REG_HALF_PERIOD;
		cfg_ch.data             = '0;
		fail_count   = 0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		recv_hold    = 0;
		slave_hold   = 0;
		stretch_left = 0;
		stretch_max  = 3;
		scl_stuck    = 1'b0;
		noisy        = 1'b0;
		prev_scl     = 1'b1;
		// predicted state after reset
		cfg_half   = HALF_PERIOD_RST;
		cfg_rise   = RISE_TIMEOUT_RST;
		cfg_maxp   = MAX_PULSES_RST;
		mdl_phase  = PH_IDLE;
		mdl_timer  = '0;
		mdl_pulses = '0;
		last_drive = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_output_stall();
		test_config_sweep();

		// nothing pending now; keep watching for stray results
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
